// ----- design/pal_pkg.sv -----
// Shared types and constants for the positional array list.
package pal_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;

    typedef enum logic [2:0] {
        KIND_INSERT = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_GET    = 3'd2,
        KIND_FIND   = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD  = 3'd0,
        CELL_LOAD  = 3'd1,
        CELL_LEFT  = 3'd2,
        CELL_RIGHT = 3'd3,
        CELL_HEAD  = 3'd4
    } cell_mode_t;

    typedef struct packed {
        logic [2:0]               kind;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         list_length;
    } rsp_t;

endpackage

// ----- design/pal_cell.sv -----
// One storage cell of the list chain: holds an entry, loads a new one, or takes one from a neighbour or the head cell.
module pal_cell
    import pal_pkg::*;
(
    input  logic                     clk,
    input  cell_mode_t               mode,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] left,
    input  logic signed [DATA_W-1:0] right,
    input  logic signed [DATA_W-1:0] head,
    output logic signed [DATA_W-1:0] data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        case (mode)
            CELL_LOAD:  data_next = value;
            CELL_LEFT:  data_next = left;
            CELL_RIGHT: data_next = right;
            CELL_HEAD:  data_next = head;
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- design/positional_array_list.sv -----
// Top level of the positional array list: cell chain, request control and result register.
// Insert, delete, clear, rejected requests: result in the cycle after the request transfer.
// Get and find: the chain rotates once through the stored entries, one cell a cycle,
// and the result is registered as the rotation ends.
// Throughput: one request a cycle unless a result stalls; get and find hold off input.
// Reset clears the entry count, the controller and the result valid flag; cells keep data.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            step_reg, step_next;
    logic                     scan_get_reg, scan_get_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     hit_reg, hit_next;
    logic signed [DATA_W-1:0] rd_reg, rd_next;
    logic [POS_W-1:0]         fpos_reg, fpos_next;
    rsp_t                     rsp_reg, rsp_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    logic                     accept;
    logic [XW-1:0]            pos_x, cnt_x, pidx_x, last_x, step_x;
    logic                     full, ins_bad, rd_bad;
    logic                     do_ins, do_del, do_rot;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    cell_mode_t               cell_mode [CAPACITY];

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;

    assign pos_x   = XW'(req.position);
    assign cnt_x   = XW'(cnt_reg);
    assign pidx_x  = pos_x - XW'(1);
    assign last_x  = cnt_x - XW'(1);
    assign step_x  = XW'(step_reg);
    assign full    = cnt_x >= XW'(CAPACITY);
    assign ins_bad = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
    assign rd_bad  = (pos_x == '0) || (pos_x > cnt_x);

    assign do_ins = accept && (req.kind == KIND_INSERT) && !full && !ins_bad;
    assign do_del = accept && (req.kind == KIND_DELETE) && !rd_bad;
    assign do_rot = (state_reg == S_SCAN);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_data;
        logic signed [DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = cell_data[0];
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        always_comb
        begin
            if (do_rot)
            begin
                cell_mode[i] = (XW'(i) == last_x) ? CELL_HEAD : CELL_RIGHT;
            end
            else if (do_ins)
            begin
                if (XW'(i) == pidx_x)
                begin
                    cell_mode[i] = CELL_LOAD;
                end
                else if (XW'(i) > pidx_x)
                begin
                    cell_mode[i] = CELL_LEFT;
                end
                else
                begin
                    cell_mode[i] = CELL_HOLD;
                end
            end
            else if (do_del && (XW'(i) >= pidx_x))
            begin
                cell_mode[i] = CELL_RIGHT;
            end
            else
            begin
                cell_mode[i] = CELL_HOLD;
            end
        end

        pal_cell u_cell (
            .clk   (clk),
            .mode  (cell_mode[i]),
            .value (req.value),
            .left  (left_data),
            .right (right_data),
            .head  (cell_data[0]),
            .data  (cell_data[i])
        );
    end

    always_comb
    begin
        rsp_t r;
        logic scan;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        scan_get_next  = scan_get_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        rd_next        = rd_reg;
        fpos_next      = fpos_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        scan           = 1'b0;

        r.status         = ST_OK;
        r.read_value     = '0;
        r.found_position = '0;
        r.list_length    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.kind)
                        KIND_INSERT:
                        begin
                            if (full)
                            begin
                                r.status = ST_FULL;
                            end
                            else if (ins_bad)
                            begin
                                r.status = ST_RANGE;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (rd_bad)
                            begin
                                r.status = ST_RANGE;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        KIND_GET:
                        begin
                            if (rd_bad)
                            begin
                                r.status = ST_RANGE;
                            end
                            else
                            begin
                                scan = 1'b1;
                            end
                        end
                        KIND_FIND:
                        begin
                            if (cnt_reg == '0)
                            begin
                                r.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                scan = 1'b1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                            r.status = ST_RANGE;
                        end
                    endcase

                    r.list_length = POS_W'(cnt_next);

                    if (scan)
                    begin
                        state_next    = S_SCAN;
                        step_next     = '0;
                        scan_get_next = (req.kind == KIND_GET);
                        pos_next      = req.position;
                        key_next      = req.value;
                        hit_next      = 1'b0;
                        rd_next       = '0;
                        fpos_next     = '0;
                    end
                    else
                    begin
                        rsp_next       = r;
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_get_reg && (step_x == XW'(pos_reg) - XW'(1)))
                begin
                    rd_next = cell_data[0];
                end
                if (!scan_get_reg && !hit_reg && (cell_data[0] == key_reg))
                begin
                    hit_next  = 1'b1;
                    fpos_next = POS_W'(step_x + XW'(1));
                end
                step_next = step_reg + CW'(1);
                if (step_x == last_x)
                begin
                    state_next       = S_IDLE;
                    r.status         = (scan_get_reg || hit_next) ? ST_OK : ST_NOTFOUND;
                    r.read_value     = rd_next;
                    r.found_position = fpos_next;
                    r.list_length    = POS_W'(cnt_reg);
                    rsp_next         = r;
                    rsp_valid_next   = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        scan_get_reg <= scan_get_next;
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        hit_reg      <= hit_next;
        rd_reg       <= rd_next;
        fpos_reg     <= fpos_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(cnt_reg) <= XW'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (req_stall && !rsp_valid_reg))
        else $error("request taken or result pending during a rotation");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (step_x < cnt_x))
        else $error("rotation step beyond entry count");

    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && (step_x == last_x)) |=>
        (rsp_valid_reg && (state_reg == S_IDLE)))
        else $error("rotation ended without a result");

endmodule

// ----- test/tb_positional_array_list.sv -----
// Self-checking testbench for the positional array list: list mirror, drivers and phases.
`timescale 1ns / 100ps

module tb_positional_array_list;
    import pal_pkg::*;

    localparam int CAPACITY = 64;
    localparam logic [2:0] KIND_SPARE_A = 3'd5;
    localparam logic [2:0] KIND_SPARE_C = 3'd7;

    class list_shadow;
        logic signed [DATA_W-1:0] entries[$];
        rsp_t                     due_replies[$];
        int                       reply_errors;
        int                       replies_seen;
        int                       room;

        function new(int cap);
            room = cap;
            reply_errors = 0;
            replies_seen = 0;
        endfunction

        function void apply_request(req_t r);
            rsp_t reply;
            int   pos;
            reply = '0;
            pos = r.position;
            reply.status = ST_OK;
            case (r.kind)
                KIND_INSERT:
                    if (entries.size() >= room)
                        reply.status = ST_FULL;
                    else if (pos < 1 || pos > entries.size() + 1)
                        reply.status = ST_RANGE;
                    else
                        entries.insert(pos - 1, r.value);
                KIND_DELETE:
                    if (pos < 1 || pos > entries.size())
                        reply.status = ST_RANGE;
                    else
                        entries.delete(pos - 1);
                KIND_GET:
                    if (pos < 1 || pos > entries.size())
                        reply.status = ST_RANGE;
                    else
                        reply.read_value = entries[pos - 1];
                KIND_FIND:
                begin
                    reply.status = ST_NOTFOUND;
                    foreach (entries[i])
                    begin
                        if (reply.status == ST_NOTFOUND && entries[i] == r.value)
                        begin
                            reply.status = ST_OK;
                            reply.found_position = POS_W'(i + 1);
                        end
                    end
                end
                KIND_CLEAR:
                    entries.delete();
                default:
                    reply.status = ST_RANGE;
            endcase
            reply.list_length = POS_W'(entries.size());
            due_replies.push_back(reply);
        endfunction

        function void compare_reply(rsp_t got);
            rsp_t due;
            replies_seen++;
            if (due_replies.size() == 0)
            begin
                reply_errors++;
                if (reply_errors <= 10)
                    $display("reply %0d unexpected: status %0d read %0d found %0d length %0d",
                             replies_seen, got.status, got.read_value, got.found_position,
                             got.list_length);
            end
            else
            begin
                due = due_replies.pop_front();
                if (got.status !== due.status || got.read_value !== due.read_value ||
                    got.found_position !== due.found_position ||
                    got.list_length !== due.list_length)
                begin
                    reply_errors++;
                    if (reply_errors <= 10)
                        $display("reply %0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 replies_seen, due.status, due.read_value, due.found_position,
                                 due.list_length, got.status, got.read_value,
                                 got.found_position, got.list_length);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int idle_pct = 0;
    int stall_pct = 0;

    list_shadow shadow = new(CAPACITY);

    positional_array_list #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            shadow.compare_reply(rsp);

    function automatic req_t request(logic [2:0] k, int pos, logic [DATA_W-1:0] v);
        req_t r;
        r.kind = k;
        r.position = POS_W'(pos);
        r.value = v;
        return r;
    endfunction

    function automatic req_t random_request(bit grow);
        req_t r;
        int   count;
        int   roll;
        int   pick;
        count = shadow.entries.size();
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        r.value = $urandom;
        if (roll < (grow ? 42 : 22))
        begin
            r.kind = KIND_INSERT;
            r.position = POS_W'($urandom_range(count + 1, 1));
            if (pick < 25)
                r.value = $signed($urandom_range(4, 0)) - 2;
        end
        else if (roll < 57)
        begin
            r.kind = KIND_DELETE;
            r.position = POS_W'(count > 0 ? $urandom_range(count, 1) : 1);
        end
        else if (roll < 77)
        begin
            r.kind = KIND_GET;
            r.position = POS_W'(count > 0 ? $urandom_range(count, 1) : 1);
        end
        else if (roll < 96)
        begin
            r.kind = KIND_FIND;
            r.position = POS_W'($urandom_range(127, 0));
            if (count > 0 && pick < 60)
                r.value = shadow.entries[$urandom_range(count - 1, 0)];
            else if (pick < 70)
                r.value = $signed($urandom_range(4, 0)) - 2;
        end
        else if (roll < 98)
        begin
            r.kind = KIND_CLEAR;
            r.position = POS_W'($urandom_range(127, 0));
        end
        else
        begin
            r.kind = 3'($urandom_range(KIND_SPARE_C, KIND_SPARE_A));
            r.position = POS_W'($urandom_range(127, 0));
        end
        if (r.kind != KIND_FIND && $urandom_range(99) < 10)
            r.position = POS_W'($urandom_range(127, 0));
        return r;
    endfunction

    task automatic issue(input req_t r);
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        shadow.apply_request(r);
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_for_replies();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (shadow.due_replies.size() != 0);
    endtask

    task automatic set_phase(int p);
        case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 13; stall_pct = 13; end
        endcase
    endtask

    task automatic fill_to_capacity();
        while (shadow.entries.size() < CAPACITY)
            issue(request(KIND_INSERT, $urandom_range(shadow.entries.size() + 1, 1), $urandom));
        issue(request(KIND_INSERT, 1, $urandom));
        issue(request(KIND_INSERT, 0, $urandom));
        issue(request(KIND_INSERT, 127, $urandom));
        issue(request(KIND_GET, CAPACITY, 0));
        issue(request(KIND_GET, CAPACITY + 1, 0));
        issue(request(KIND_FIND, 0, shadow.entries[CAPACITY - 1]));
        issue(request(KIND_DELETE, CAPACITY, 0));
        issue(request(KIND_INSERT, CAPACITY, $urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_phase(0);

        issue(request(KIND_GET, 1, 0));
        issue(request(KIND_DELETE, 1, 0));
        issue(request(KIND_FIND, 0, 0));
        issue(request(KIND_INSERT, 0, 32'h0000_0005));
        issue(request(KIND_INSERT, 2, 32'h0000_0005));
        issue(request(KIND_INSERT, 1, 32'h8000_0000));
        issue(request(KIND_INSERT, 2, 32'h7fff_ffff));
        issue(request(KIND_INSERT, 1, 32'hffff_ffff));
        issue(request(KIND_INSERT, 127, 32'h0000_0001));
        issue(request(KIND_GET, 1, 0));
        issue(request(KIND_GET, 3, 0));
        issue(request(KIND_GET, 4, 0));
        issue(request(KIND_GET, 0, 0));
        issue(request(KIND_FIND, 0, 32'h7fff_ffff));
        issue(request(KIND_INSERT, 4, 32'hffff_ffff));
        issue(request(KIND_FIND, 127, 32'hffff_ffff));
        issue(request(KIND_FIND, 0, 0));
        issue(request(KIND_DELETE, 4, 0));
        issue(request(KIND_DELETE, 1, 0));
        issue(request(KIND_DELETE, 0, 0));
        issue(request(KIND_SPARE_A, 1, 32'h1234_5678));
        issue(request(KIND_SPARE_A + 3'd1, 127, 32'hffff_ffff));
        issue(request(KIND_SPARE_C, 2, 32'h8000_0000));
        issue(request(KIND_CLEAR, 3, 32'h0000_0001));
        issue(request(KIND_GET, 1, 0));

        for (int seg = 0; seg < 8; seg++)
        begin
            wait_for_replies();
            set_phase(seg);
            if (seg % 3 == 0)
                fill_to_capacity();
            for (int n = 0; n < 110; n++)
                issue(random_request((n / 20) % 2 == 0));
        end

        wait_for_replies();
        repeat (CAPACITY + 8) @(negedge clk);
        if (shadow.reply_errors == 0 && shadow.due_replies.size() == 0)
            $display("tb_positional_array_list: clean");
        else
            $display("tb_positional_array_list: errors");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb_positional_array_list: errors");
        $finish;
    end

endmodule
